@@ design/tbpd_pkg.sv @@
package tbpd_pkg;

	localparam int unsigned DIV_W   = 53;
	localparam int unsigned QUO_W   = 34;
	localparam logic [52:0] RECIP   = 53'd4722366482869646;

	localparam logic [15:0] DEADBAND_HZ = 16'd20;

	localparam logic signed [25:0] K098  = 26'sd16441672;
	localparam logic signed [25:0] K002  = 26'sd335544;
	localparam logic signed [25:0] K0999 = 26'sd16760439;
	localparam logic signed [32:0] ONE_Q24 = 33'sd16777216;
	localparam logic [16:0] W_ONE = 17'd65536;

	localparam logic [2:0] REG_GAIN_P   = 3'd0;
	localparam logic [2:0] REG_GAIN_I   = 3'd1;
	localparam logic [2:0] REG_GAIN_D   = 3'd2;
	localparam logic [2:0] REG_RATE_W   = 3'd3;
	localparam logic [2:0] REG_SETPOINT = 3'd4;
	localparam logic [2:0] REG_MAX_RATE = 3'd5;
	localparam logic [2:0] REG_SCALE    = 3'd6;

	localparam logic [3:0] OP_INC = 4'd0;
	localparam logic [3:0] OP_T1  = 4'd1;
	localparam logic [3:0] OP_T2  = 4'd2;
	localparam logic [3:0] OP_E   = 4'd3;
	localparam logic [3:0] OP_I1  = 4'd4;
	localparam logic [3:0] OP_I2  = 4'd5;
	localparam logic [3:0] OP_R1  = 4'd6;
	localparam logic [3:0] OP_R2  = 4'd7;
	localparam logic [3:0] OP_P1  = 4'd8;
	localparam logic [3:0] OP_P2  = 4'd9;
	localparam logic [3:0] OP_P3  = 4'd10;
	localparam logic [3:0] OP_F   = 4'd11;

	typedef struct packed {
		logic [3:0] op;
		logic       load_in;
		logic       mul;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic slot_free;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607)
			return 24'sh7fffff;
		else if (v < -64'sd8388608)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

endpackage

@@ design/tbpd_div.sv @@
module tbpd_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [tbpd_pkg::DIV_W-1:0]    dividend,
	output logic                                 done,
	output logic signed [tbpd_pkg::QUO_W-1:0]    quotient
);
	import tbpd_pkg::*;

	logic         busy_q, done_q, neg_q;
	logic [1:0]   step_q;
	logic [51:0]  mag_q;
	logic [104:0] acc_q;
	logic [51:0]  mag;
	logic [25:0]  part_a;
	logic [26:0]  part_b;
	logic [52:0]  part_p;
	logic [104:0] part_sh;
	logic signed [QUO_W-1:0] q;

	// magnitude times ceil(2^72 / 1000000), upper bits are the quotient
	assign mag    = 52'(dividend[DIV_W-1] ? -dividend : dividend);
	assign part_a = step_q[1] ? mag_q[51:26] : mag_q[25:0];
	assign part_b = step_q[0] ? RECIP[52:26] : {1'b0, RECIP[25:0]};
	assign part_p = part_a * part_b;
	assign q      = {1'b0, acc_q[104:72]};

	always_comb begin
		case (step_q)
			2'd0:    part_sh = 105'(part_p);
			2'd3:    part_sh = {part_p, 52'b0};
			default: part_sh = {26'b0, part_p, 26'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIV_W-1];
			mag_q <= mag;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part_sh;
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -q : q;

endmodule

@@ design/tbpd_datapath.sv @@
module tbpd_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbpd_pkg::cmd_t         cmd,
	output tbpd_pkg::status_t      status,
	input  logic                   cfg_valid,
	input  logic [2:0]             cfg_index,
	input  logic [23:0]            cfg_data,
	input  logic signed [15:0]     accel_tilt,
	input  logic signed [15:0]     gyro_rate,
	input  logic [15:0]            elapsed_us,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [23:0]     drive_value,
	output logic [15:0]            step_rate,
	output logic                   motors_run,
	output logic                   left_forward,
	output logic                   right_forward
);
	import tbpd_pkg::*;

	logic [23:0] gain_p_q, gain_i_q, gain_d_q;
	logic [16:0] rate_w_q;
	logic signed [15:0] setpoint_q;
	logic [15:0] max_rate_q, scale_q;

	logic signed [15:0] accel_q, gyro_q;
	logic [15:0] dt_q;

	logic signed [31:0] tilt_q, integral_q, rate_q, err_q;
	logic signed [23:0] drive_q, drive_out_q;
	logic signed [QUO_W-1:0] divq_q;
	logic signed [63:0] acc_q;
	logic signed [61:0] prod_q;
	logic left_q, right_q;
	logic out_valid_q, run_q;
	logic [15:0] step_q;

	logic signed [35:0] opa;
	logic signed [25:0] opb;
	logic signed [61:0] mul_p;
	logic signed [17:0] w;
	logic signed [31:0] accel_sat, sp_sat, err_raw;
	logic signed [32:0] err_mag;
	logic err_small;
	logic signed [63:0] p64, sum64;
	logic div_start, div_done;
	logic signed [DIV_W-1:0] dividend;
	logic signed [QUO_W-1:0] quotient;
	logic signed [39:0] freq;
	logic [39:0] fmag;
	logic [31:0] rate_raw;
	logic [15:0] rate_cap;
	logic run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= 24'd458752;
			gain_i_q   <= 24'd13107;
			gain_d_q   <= 24'd6554;
			rate_w_q   <= 17'd3277;
			setpoint_q <= -16'sd109;
			max_rate_q <= 16'd12000;
			scale_q    <= 16'd250;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN_P:   gain_p_q   <= cfg_data;
				REG_GAIN_I:   gain_i_q   <= cfg_data;
				REG_GAIN_D:   gain_d_q   <= cfg_data;
				REG_RATE_W:   rate_w_q   <= cfg_data[16:0];
				REG_SETPOINT: setpoint_q <= cfg_data[15:0];
				REG_MAX_RATE: max_rate_q <= cfg_data[15:0];
				REG_SCALE:    scale_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign w         = (rate_w_q > W_ONE) ? $signed({1'b0, W_ONE}) : $signed({1'b0, rate_w_q});
	assign accel_sat = sat32(64'($signed({accel_q, 17'b0})));
	assign sp_sat    = sat32(64'($signed({setpoint_q, 17'b0})));
	assign err_raw   = sat32(64'(sp_sat) - 64'(tilt_q));
	assign err_mag   = err_raw[31] ? -33'(err_raw) : 33'(err_raw);
	assign err_small = err_mag < ONE_Q24;

	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.op)
			OP_INC: begin
				opa = 36'(gyro_q);
				opb = 26'($signed({1'b0, dt_q}));
			end
			OP_T1: begin
				opa = 36'(tilt_q) + 36'(divq_q);
				opb = K098;
			end
			OP_T2: begin
				opa = 36'(accel_sat);
				opb = K002;
			end
			OP_E: begin
				opa = 36'(err_raw);
				opb = 26'($signed({1'b0, err_mag[24:0]}));
			end
			OP_I1: begin
				opa = 36'(err_q);
				opb = 26'($signed({1'b0, dt_q}));
			end
			OP_I2: begin
				opa = 36'(integral_q) + 36'(divq_q);
				opb = K0999;
			end
			OP_R1: begin
				opa = 36'($signed({-17'(gyro_q), 16'b0}));
				opb = 26'(w);
			end
			OP_R2: begin
				opa = 36'(rate_q);
				opb = 26'($signed({1'b0, W_ONE}) - w);
			end
			OP_P1: begin
				opa = 36'(err_q);
				opb = 26'($signed({1'b0, gain_p_q}));
			end
			OP_P2: begin
				opa = 36'(integral_q);
				opb = 26'($signed({1'b0, gain_i_q}));
			end
			OP_P3: begin
				opa = 36'(rate_q);
				opb = 26'($signed({1'b0, gain_d_q}));
			end
			OP_F: begin
				opa = 36'(drive_q);
				opb = 26'($signed({1'b0, scale_q}));
			end
			default: ;
		endcase
	end

	assign mul_p = opa * opb;

	assign p64   = 64'(prod_q);
	assign sum64 = (cmd.op == OP_P3) ? acc_q + (p64 <<< 4) : acc_q + p64;

	assign freq     = prod_q[39:0];
	assign fmag     = freq[39] ? 40'(-freq) : 40'(freq);
	assign rate_raw = fmag[39:8];
	assign rate_cap = (rate_raw > 32'(max_rate_q)) ? max_rate_q : rate_raw[15:0];
	assign run      = rate_cap >= DEADBAND_HZ;

	assign div_start = cmd.fin && (cmd.op == OP_INC || cmd.op == OP_I1);
	assign dividend  = (cmd.op == OP_INC) ? {prod_q[32:0], 20'b0} : prod_q[52:0];

	tbpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			accel_q <= accel_tilt;
			gyro_q  <= gyro_rate;
			dt_q    <= elapsed_us;
		end
		if (cmd.mul)
			prod_q <= mul_p;
		if (div_done)
			divq_q <= quotient;
		if (cmd.fin) begin
			case (cmd.op)
				OP_T1, OP_R1, OP_P1: acc_q <= p64;
				OP_P2:               acc_q <= sum64;
				OP_E:                err_q <= err_small ?
					32'((p64 + (64'sd1 <<< 23)) >>> 24) : err_raw;
				default: ;
			endcase
		end
		if (cmd.fin && cmd.op == OP_F) begin
			step_q      <= run ? rate_cap : 16'd0;
			run_q       <= run;
			drive_out_q <= drive_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q      <= '0;
			integral_q  <= '0;
			rate_q      <= '0;
			left_q      <= 1'b0;
			right_q     <= 1'b0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
		end else begin
			if (cmd.fin) begin
				case (cmd.op)
					OP_T2: tilt_q     <= sat32((sum64 + (64'sd1 <<< 23)) >>> 24);
					OP_I2: integral_q <= sat32((p64 + (64'sd1 <<< 23)) >>> 24);
					OP_R2: rate_q     <= sat32((sum64 + (64'sd1 <<< 15)) >>> 16);
					OP_P3: drive_q    <= sat24((sum64 + (64'sd1 <<< 31)) >>> 32);
					OP_F: begin
						if (run) begin
							left_q  <= !freq[39] && (freq != 40'sd0);
							right_q <= freq[39];
						end
					end
					default: ;
				endcase
			end
			if (cmd.fin && cmd.op == OP_F)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign status.div_done  = div_done;
	assign status.slot_free = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign drive_value   = drive_out_q;
	assign step_rate     = step_q;
	assign motors_run    = run_q;
	assign left_forward  = left_q;
	assign right_forward = right_q;

endmodule

@@ design/tbpd_ctrl.sv @@
module tbpd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tbpd_pkg::status_t   status,
	output tbpd_pkg::cmd_t      cmd
);
	import tbpd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0] state_q;
	logic [3:0] op_q;
	logic       fin_ok;

	assign fin_ok = (op_q != OP_F) || status.slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_INC;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_MUL;
					op_q    <= OP_INC;
				end
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: if (fin_ok) begin
					if (op_q == OP_INC || op_q == OP_I1)
						state_q <= ST_WAIT;
					else if (op_q == OP_F)
						state_q <= ST_IDLE;
					else begin
						state_q <= ST_MUL;
						op_q    <= op_q + 4'd1;
					end
				end
				ST_WAIT: if (status.div_done) begin
					state_q <= ST_MUL;
					op_q    <= op_q + 4'd1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = state_q != ST_IDLE;
	assign cmd.op      = op_q;
	assign cmd.load_in = (state_q == ST_IDLE) && in_valid;
	assign cmd.mul     = state_q == ST_MUL;
	assign cmd.fin     = (state_q == ST_FIN) && fin_ok;

endmodule

@@ design/tilt_balance_pid_drive.sv @@
// Tilt balance drive: complementary filter, leaky PID and step-rate output for two
// opposed steppers. One sample is taken at a time; its processing runs on one shared
// multiplier stepped over twelve products (a multiply step and a finish step each)
// and a divide by 1000000 run twice as a reciprocal multiply over four partial
// products. A new sample is accepted the cycle after the previous one finishes; a
// result still waiting in the output register holds the next sample at its last step.
// Config writes are always ready.
module tilt_balance_pid_drive (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_tilt,
	input  logic signed [15:0] gyro_rate,
	input  logic [15:0]        elapsed_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] drive_value,
	output logic [15:0]        step_rate,
	output logic               motors_run,
	output logic               left_forward,
	output logic               right_forward
);
	import tbpd_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tbpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tbpd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accel_tilt    (accel_tilt),
		.gyro_rate     (gyro_rate),
		.elapsed_us    (elapsed_us),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive_value   (drive_value),
		.step_rate     (step_rate),
		.motors_run    (motors_run),
		.left_forward  (left_forward),
		.right_forward (right_forward)
	);

endmodule

@@ tb/sv/tilt_balance_pid_drive_tb.sv @@
`timescale 1ns / 1ps

module tilt_balance_pid_drive_tb;
	import tbpd_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 20000;
	localparam longint K098_L = 16441672;
	localparam longint K002_L = 335544;
	localparam longint K0999_L = 16760439;
	localparam longint ONE_L = 16777216;
	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint I32_MAX = 64'sd2147483647;

	typedef struct packed {
		logic signed [23:0] drive;
		logic [15:0]        rate;
		logic               run;
		logic               left_fwd;
		logic               right_fwd;
	} drive_word_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] accel_tilt;
	logic signed [15:0] gyro_rate;
	logic [15:0]        elapsed_us;
	logic               out_valid;
	logic               out_stall;
	logic signed [23:0] drive_value;
	logic [15:0]        step_rate;
	logic               motors_run;
	logic               left_forward;
	logic               right_forward;

	tilt_balance_pid_drive i_dut (.*);

	// controller copy
	logic [23:0]        kp, ki, kd;
	logic [16:0]        rate_w;
	logic signed [15:0] setpoint;
	logic [15:0]        rate_cap, hz_scale;
	logic signed [31:0] tilt_q, integ_q, rate_q;
	logic               left_latch, right_latch;

	drive_word_t expected_words[$];
	int          fails = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          max_gap = 8;
	int          stall_pct = 30;
	bit          hold_req = 0;
	int          hold_cnt = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic longint rnd_shr(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic drive_word_t balance_step(input logic signed [15:0] a,
			input logic signed [15:0] g, input logic [15:0] dt);
		longint accel_q, sp_q, incr, acc, err, mag, w, pid, drv, freq, rate;
		drive_word_t r;
		accel_q = clip(longint'(a) * 131072, I32_MIN, I32_MAX);
		sp_q = clip(longint'(setpoint) * 131072, I32_MIN, I32_MAX);
		incr = (longint'(g) * longint'(dt) * 1048576) / 1000000;
		acc = (longint'(tilt_q) + incr) * K098_L + accel_q * K002_L;
		tilt_q = clip(rnd_shr(acc, 24), I32_MIN, I32_MAX);
		err = clip(sp_q - longint'(tilt_q), I32_MIN, I32_MAX);
		mag = err < 0 ? -err : err;
		if (mag < ONE_L)
			err = rnd_shr(err * mag, 24);
		acc = longint'(integ_q) + (err * longint'(dt)) / 1000000;
		integ_q = clip(rnd_shr(acc * K0999_L, 24), I32_MIN, I32_MAX);
		w = rate_w > 17'd65536 ? 65536 : longint'(rate_w);
		rate_q = clip(rnd_shr(w * (-longint'(g) * 65536) + (65536 - w) * longint'(rate_q), 16),
			I32_MIN, I32_MAX);
		pid = longint'(kp) * err + longint'(ki) * longint'(integ_q)
			+ longint'(kd) * longint'(rate_q) * 16;
		drv = clip(rnd_shr(pid, 32), -8388608, 8388607);
		freq = drv * longint'(hz_scale);
		rate = (freq < 0 ? -freq : freq) >>> 8;
		if (rate > longint'(rate_cap))
			rate = rate_cap;
		r.run = rate >= longint'(DEADBAND_HZ);
		if (r.run) begin
			left_latch = freq > 0;
			right_latch = freq < 0;
		end else begin
			rate = 0;
		end
		r.drive = drv[23:0];
		r.rate = rate[15:0];
		r.left_fwd = left_latch;
		r.right_fwd = right_latch;
		return r;
	endfunction

	task automatic wait_drained();
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		wait_drained();
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_P: kp = data;
			REG_GAIN_I: ki = data;
			REG_GAIN_D: kd = data;
			REG_RATE_W: rate_w = data[16:0];
			REG_SETPOINT: setpoint = data[15:0];
			REG_MAX_RATE: rate_cap = data[15:0];
			REG_SCALE: hz_scale = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_sample(input logic signed [15:0] a, input logic signed [15:0] g,
			input logic [15:0] dt);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (max_gap > 0) begin
				in_valid = 0;
				repeat ($urandom_range(0, max_gap)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1;
		accel_tilt = a;
		gyro_rate = g;
		elapsed_us = dt;
		do @(posedge clk); while (in_stall);
		expected_words.push_back(balance_step(a, g, dt));
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic idle_input();
		in_valid = 0;
		@(negedge clk);
	endtask

	task automatic random_sample(input int realistic);
		logic signed [15:0] a, g;
		logic [15:0] dt;
		if (realistic) begin
			a = setpoint + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
			g = $signed(16'($urandom_range(0, 3000))) - 16'sd1500;
			dt = 16'($urandom_range(3000, 7000));
		end else begin
			a = 16'($urandom);
			g = 16'($urandom);
			dt = 16'($urandom);
		end
		send_sample(a, g, dt);
	endtask

	task automatic test_field_extremes();
		send_sample(16'sh7fff, 16'sh7fff, 16'hffff);
		send_sample(16'sh7fff, 16'sh7fff, 16'hffff);
		send_sample(-16'sh8000, -16'sh8000, 16'hffff);
		send_sample(-16'sh8000, -16'sh8000, 16'hffff);
		send_sample(16'sd0, 16'sd0, 16'd0);
		send_sample(-16'sd109, 16'sd0, 16'd5000);
		send_sample(-16'sd100, 16'sd3, 16'd5000);
		send_sample(-16'sd120, -16'sd3, 16'd5000);
		send_sample(16'sd500, 16'sd40, 16'd5000);
		send_sample(-16'sd700, -16'sd40, 16'd5000);
		send_sample(16'sh5555, 16'shaaaa, 16'h5555);
		send_sample(16'shaaaa, 16'sh5555, 16'haaaa);
		idle_input();
	endtask

	task automatic test_register_settings();
		write_reg(REG_RATE_W, 24'h1ffff);
		send_sample(16'sd300, 16'sd1000, 16'd4000);
		send_sample(16'sd300, -16'sd1000, 16'd4000);
		write_reg(REG_RATE_W, 24'd0);
		send_sample(16'sd300, 16'sd1000, 16'd4000);
		write_reg(REG_RATE_W, 24'd65536);
		write_reg(REG_GAIN_P, 24'hffffff);
		write_reg(REG_GAIN_I, 24'hffffff);
		write_reg(REG_GAIN_D, 24'hffffff);
		write_reg(REG_SETPOINT, 24'h007fff);
		write_reg(REG_MAX_RATE, 24'hffff);
		write_reg(REG_SCALE, 24'hffff);
		send_sample(-16'sh8000, 16'sh7fff, 16'hffff);
		send_sample(16'sh7fff, -16'sh8000, 16'hffff);
		write_reg(REG_SETPOINT, 24'h008000);
		send_sample(16'sh7fff, -16'sh8000, 16'hffff);
		write_reg(REG_UNUSED, 24'h123456);
		write_reg(REG_GAIN_P, 24'd0);
		write_reg(REG_GAIN_I, 24'd0);
		write_reg(REG_GAIN_D, 24'd0);
		write_reg(REG_MAX_RATE, 24'd0);
		write_reg(REG_SCALE, 24'd0);
		send_sample(16'sd1000, 16'sd1000, 16'd5000);
		idle_input();
	endtask

	task automatic run_random_phase(input int count, input int realistic_pct);
		repeat (count)
			random_sample($urandom_range(0, 99) < realistic_pct);
		idle_input();
	endtask

	task automatic test_random_settings();
		write_reg(REG_GAIN_P, 24'd458752);
		write_reg(REG_GAIN_I, 24'd13107);
		write_reg(REG_GAIN_D, 24'd6554);
		write_reg(REG_RATE_W, 24'd3277);
		write_reg(REG_SETPOINT, 24'hffff93);
		write_reg(REG_MAX_RATE, 24'd12000);
		write_reg(REG_SCALE, 24'd250);
		run_random_phase(200, 80);
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_GAIN_P, 24'($urandom_range(0, 2000000)));
			write_reg(REG_GAIN_I, 24'($urandom_range(0, 200000)));
			write_reg(REG_GAIN_D, 24'($urandom_range(0, 100000)));
			write_reg(REG_RATE_W, 24'($urandom_range(0, 70000)));
			write_reg(REG_SETPOINT, 24'($urandom_range(0, 1000) - 500));
			write_reg(REG_MAX_RATE, 24'($urandom));
			write_reg(REG_SCALE, 24'($urandom_range(0, 2000)));
			stall_pct = (p == 2) ? 0 : $urandom_range(10, 70);
			max_gap = (p == 1) ? 0 : 8;
			run_random_phase(120, 75);
		end
		stall_pct = 30;
		max_gap = 8;
	endtask

	task automatic test_output_hold();
		hold_req = 1;
		run_random_phase(20, 80);
		wait_drained();
		run_random_phase(40, 80);
		wait_drained();
		run_random_phase(40, 80);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req <= 0;
			hold_cnt <= 1500;
			out_stall <= 1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		drive_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: drive_value %0d", drive_value);
				fails++;
			end else begin
				e = expected_words.pop_front();
				if (drive_value !== e.drive) begin
					$error("drive_value exp %0d got %0d", e.drive, drive_value);
					fails++;
				end
				if (step_rate !== e.rate) begin
					$error("step_rate exp %0d got %0d", e.rate, step_rate);
					fails++;
				end
				if (motors_run !== e.run) begin
					$error("motors_run exp %0b got %0b", e.run, motors_run);
					fails++;
				end
				if (left_forward !== e.left_fwd) begin
					$error("left_forward exp %0b got %0b", e.left_fwd, left_forward);
					fails++;
				end
				if (right_forward !== e.right_fwd) begin
					$error("right_forward exp %0b got %0b", e.right_fwd, right_forward);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[tilt_balance_pid_drive] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		accel_tilt = '0;
		gyro_rate = '0;
		elapsed_us = '0;
		out_stall = 0;
		kp = 24'd458752;
		ki = 24'd13107;
		kd = 24'd6554;
		rate_w = 17'd3277;
		setpoint = -16'sd109;
		rate_cap = 16'd12000;
		hz_scale = 16'd250;
		tilt_q = '0;
		integ_q = '0;
		rate_q = '0;
		left_latch = 0;
		right_latch = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_field_extremes();
		test_register_settings();
		test_random_settings();
		test_output_hold();
		wait_drained();
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("[tilt_balance_pid_drive] OK");
		else
			$display("[tilt_balance_pid_drive] ERROR");
		$finish;
	end

endmodule
